// ----- src/prsq_pkg.sv -----
// ----------------------------------------------------------------------------
// prsq_pkg
// shared types, constants and helpers of the per-receiver sender queues
// ----------------------------------------------------------------------------
package prsq_pkg;

    // number of task ids held in the tables
    localparam int TASKS   = 64;
    // width of a task id field on the ports
    localparam int ID_W    = 6;
    // width of a table index
    localparam int TASK_AW = (TASKS > 1) ? $clog2(TASKS) : 1;

    // operation codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    typedef enum logic [1:0] {
        MARK_NONE          = 2'd0,
        MARK_SEND_BLOCKED  = 2'd1,
        MARK_REPLY_BLOCKED = 2'd2
    } t_mark;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_WR
    } t_state;

    // receiver table entry
    typedef struct packed {
        logic [ID_W-1:0] head;
        logic [ID_W-1:0] tail;
    } t_rx_word;

    // task table entry: next-link and block mark
    typedef struct packed {
        logic            link_vld;
        logic [ID_W-1:0] link_id;
        t_mark           mark;
    } t_task_word;

    localparam int RX_W   = $bits(t_rx_word);
    localparam int TASK_W = $bits(t_task_word);

    function automatic logic id_in_range(input logic [ID_W-1:0] id);
        return {{(32-ID_W){1'b0}}, id} < 32'(TASKS);
    endfunction

    function automatic logic [TASK_AW-1:0] to_idx(input logic [ID_W-1:0] id);
        return TASK_AW'(id);
    endfunction

endpackage

// ----- src/prsq_ram.sv -----
// ----------------------------------------------------------------------------
// prsq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module prsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/per_receiver_sender_queues_core.sv -----
// ----------------------------------------------------------------------------
// per_receiver_sender_queues_core
// one linked-list fifo of waiting senders per receiving task
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Each transaction
// produces exactly one result, shown for one cycle with o_done high; the
// receiver cannot stall, so it must capture the result in that cycle. A push
// appends i_sender_id to the queue of i_receiver_id and marks the sender
// send-blocked (an out-of-range push is dropped); its result is always
// popped_valid 0, popped_sender 0. A pop removes the oldest sender of the
// queue, marks it reply-blocked and returns it, or returns popped_valid 0 on
// an empty queue. Every transaction reads the receiver table in S_RD1; a pop
// of a non-empty queue adds S_RD2, a push to a non-empty queue S_RD2 and S_WR.
// busy drops as o_done rises, so the next start can follow directly. The steps
// come from the read-modify-write of the receiver table (head, tail), then the
// task table (links, marks), both synchronous rams with registered read data.
// Non-empty flags and task table valid bits are flip-flops cleared at reset,
// so no clearing pass is needed and transactions are taken right after reset.
module per_receiver_sender_queues_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_func,
    input  logic [prsq_pkg::ID_W-1:0] i_receiver_id,
    input  logic [prsq_pkg::ID_W-1:0] i_sender_id,
    output logic                   o_done,
    output logic                   o_popped_valid,
    output logic [prsq_pkg::ID_W-1:0] o_popped_sender
);

    import prsq_pkg::*;

    // control state
    t_state             r_state, n_state;
    logic [TASKS-1:0]   r_ne;        // queue non-empty flags
    logic [TASKS-1:0]   r_tvld;      // task table entry written since reset
    logic               r_tk_rvld;   // valid bit of the entry being read
    logic               r_done;

    // transaction and working registers
    logic               r_func;
    logic [ID_W-1:0]    r_rcv;
    logic [ID_W-1:0]    r_snd;
    logic [ID_W-1:0]    r_head, n_head;
    logic [ID_W-1:0]    r_tail, n_tail;
    logic               r_pvalid, n_pvalid;
    logic [ID_W-1:0]    r_psender, n_psender;

    // ram ports
    logic               rx_we;
    logic [TASK_AW-1:0] rx_waddr;
    t_rx_word           rx_wdata;
    logic [TASK_AW-1:0] rx_raddr;
    t_rx_word           rx_rdata;

    logic               tk_we;
    logic [TASK_AW-1:0] tk_waddr;
    t_task_word         tk_wdata;
    logic [TASK_AW-1:0] tk_raddr;
    t_task_word         tk_rdata;
    t_task_word         tk_word;

    logic               accept;
    logic               ne_set;
    logic               ne_clr;
    logic               done_set;
    logic               rcv_ok;
    logic               snd_ok;
    logic               rcv_ne;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign rcv_ok = id_in_range(r_rcv);
    assign snd_ok = id_in_range(r_snd);
    assign rcv_ne = r_ne[to_idx(r_rcv)];

    // never-written task entries read as the reset value
    assign tk_word = r_tk_rvld ? tk_rdata : t_task_word'('0);

    // receiver table: head and tail per receiver
    prsq_ram #(
        .WIDTH (RX_W),
        .DEPTH (TASKS)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (rx_wdata),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rdata)
    );

    // task table: next-link and block mark per task
    prsq_ram #(
        .WIDTH (TASK_W),
        .DEPTH (TASKS)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (tk_we),
        .i_waddr (tk_waddr),
        .i_wdata (tk_wdata),
        .i_raddr (tk_raddr),
        .o_rdata (tk_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                if (r_func == FUNC_PUSH) begin
                    // only a push to a non-empty queue needs the old tail link
                    n_state = (rcv_ok && snd_ok && rcv_ne) ? S_RD2 : S_IDLE;
                end else begin
                    n_state = (rcv_ok && rcv_ne) ? S_RD2 : S_IDLE;
                end
            end
            S_RD2: begin
                n_state = (r_func == FUNC_PUSH) ? S_WR : S_IDLE;
            end
            S_WR: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb begin
        rx_raddr  = to_idx(i_receiver_id);
        rx_we     = 1'b0;
        rx_waddr  = to_idx(r_rcv);
        rx_wdata  = rx_rdata;
        tk_raddr  = (r_func == FUNC_PUSH) ? to_idx(rx_rdata.tail) : to_idx(rx_rdata.head);
        tk_we     = 1'b0;
        tk_waddr  = to_idx(r_snd);
        tk_wdata  = '{link_vld: 1'b0, link_id: '0, mark: MARK_SEND_BLOCKED};
        ne_set    = 1'b0;
        ne_clr    = 1'b0;
        done_set  = 1'b0;
        n_head    = r_head;
        n_tail    = r_tail;
        n_pvalid  = 1'b0;
        n_psender = '0;
        case (r_state)
            S_RD1: begin
                n_head = rx_rdata.head;
                n_tail = rx_rdata.tail;
                if (r_func == FUNC_PUSH) begin
                    if (!(rcv_ok && snd_ok)) begin
                        // out-of-range push is dropped
                        done_set = 1'b1;
                    end else if (!rcv_ne) begin
                        // first sender: head and tail both point at it
                        rx_we    = 1'b1;
                        rx_wdata = '{head: r_snd, tail: r_snd};
                        ne_set   = 1'b1;
                        tk_we    = 1'b1;
                        done_set = 1'b1;
                    end else begin
                        rx_we    = 1'b1;
                        rx_wdata = '{head: rx_rdata.head, tail: r_snd};
                    end
                end else if (!(rcv_ok && rcv_ne)) begin
                    // empty pop
                    done_set = 1'b1;
                end
            end
            S_RD2: begin
                if (r_func == FUNC_PUSH) begin
                    // link old tail to the new sender, keep its mark
                    tk_we    = 1'b1;
                    tk_waddr = to_idx(r_tail);
                    tk_wdata = '{link_vld: 1'b1, link_id: r_snd, mark: tk_word.mark};
                end else begin
                    if (tk_word.link_vld) begin
                        rx_we    = 1'b1;
                        rx_wdata = '{head: tk_word.link_id, tail: r_tail};
                    end else begin
                        ne_clr = 1'b1;
                    end
                    tk_we     = 1'b1;
                    tk_waddr  = to_idx(r_head);
                    tk_wdata  = '{link_vld: tk_word.link_vld, link_id: tk_word.link_id,
                                  mark: MARK_REPLY_BLOCKED};
                    done_set  = 1'b1;
                    n_pvalid  = 1'b1;
                    n_psender = r_head;
                end
            end
            S_WR: begin
                // new sender ends the list; written after the tail link so a
                // duplicate push leaves its own link cleared
                tk_we    = 1'b1;
                done_set = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ne      <= '0;
            r_tvld    <= '0;
            r_tk_rvld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_done    <= done_set;
            r_tk_rvld <= r_tvld[tk_raddr];
            if (ne_set) begin
                r_ne[to_idx(r_rcv)] <= 1'b1;
            end else if (ne_clr) begin
                r_ne[to_idx(r_rcv)] <= 1'b0;
            end
            if (tk_we) begin
                r_tvld[tk_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_rcv  <= i_receiver_id;
            r_snd  <= i_sender_id;
        end
        r_head <= n_head;
        r_tail <= n_tail;
        if (done_set) begin
            r_pvalid  <= n_pvalid;
            r_psender <= n_psender;
        end
    end

    assign o_done          = r_done;
    assign o_popped_valid  = r_pvalid;
    assign o_popped_sender = r_psender;

    // a result follows only from a transaction in flight
    a_done_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state != S_IDLE))
        else $error("result without a transaction in flight");

    // a taken transaction makes the block busy
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy did not rise after start");

    // a popped sender is only reported for a pop
    a_valid_only_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_pvalid) |-> (r_func == FUNC_POP))
        else $error("popped sender on a push");

    // the tables are never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tk_we || rx_we) |-> (r_state != S_IDLE))
        else $error("table write while idle");

endmodule
